// File: rtl/tphc_pkg.sv
// ============================================================================
// tphc_pkg
// Shared types and constants of the two-point temperature and humidity
// calibration core.
// ============================================================================
`default_nettype none

package tphc_pkg;

    // Pipeline shape: four front stages, one cell per quotient bit, one
    // output register.
    localparam int C_FRONT  = 4;
    localparam int C_CELLS  = 17;
    localparam int C_STAGES = C_FRONT + C_CELLS + 1;

    // Scaling of the numerator: x8 for temperature, x64 for humidity.
    localparam int C_TEMP_SHIFT = 3;
    localparam int C_HUM_SHIFT  = 6;

    localparam logic [15:0] C_OUT_MAX  = 16'h7fff;
    localparam logic [15:0] C_OUT_MIN  = 16'h8000;
    localparam logic [15:0] C_OUT_ZERO = 16'h0000;
    localparam logic [16:0] C_POS_LIM  = 17'd32767;
    localparam logic [16:0] C_NEG_LIM  = 17'd32768;

    // Configuration register indexes.
    localparam int          C_IDX_W              = 4;
    localparam int          C_CFG_DATA_W         = 16;
    localparam logic [3:0]  C_REG_HUM_LOW_PT     = 4'd0;
    localparam logic [3:0]  C_REG_HUM_HIGH_PT    = 4'd1;
    localparam logic [3:0]  C_REG_TEMP_LOW_PT    = 4'd2;
    localparam logic [3:0]  C_REG_TEMP_HIGH_PT   = 4'd3;
    localparam logic [3:0]  C_REG_HUM_LOW_RAW    = 4'd4;
    localparam logic [3:0]  C_REG_HUM_HIGH_RAW   = 4'd5;
    localparam logic [3:0]  C_REG_TEMP_LOW_RAW   = 4'd6;
    localparam logic [3:0]  C_REG_TEMP_HIGH_RAW  = 4'd7;

    typedef struct packed {
        logic signed [15:0] temp_sample;
        logic signed [15:0] hum_sample;
    } t_in;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic signed [15:0] humidity;
        logic               temp_invalid;
        logic               hum_invalid;
    } t_out;

    typedef struct packed {
        logic [7:0]         hum_low_point_x2;
        logic [7:0]         hum_high_point_x2;
        logic [9:0]         temp_low_point_x8;
        logic [9:0]         temp_high_point_x8;
        logic signed [15:0] hum_low_raw;
        logic signed [15:0] hum_high_raw;
        logic signed [15:0] temp_low_raw;
        logic signed [15:0] temp_high_raw;
    } t_cfg;

    // Division state of one channel as it moves down the cell row.
    typedef struct packed {
        logic [15:0] rem;   // partial remainder, below den unless ovf is set
        logic [15:0] den;   // divisor magnitude
        logic [16:0] lo;    // numerator bits still to be shifted in, MSB first
        logic [16:0] quo;   // quotient magnitude bits collected so far
        logic        neg;   // result is negative
        logic        zero;  // numerator is zero
        logic        ovf;   // quotient does not fit, or divisor is zero
    } t_div;

    typedef struct packed {
        t_div temp;
        t_div hum;
    } t_div_pair;

endpackage

`default_nettype wire

// File: rtl/tphc_front.sv
// ============================================================================
// tphc_front
// Front stages: products, numerator sum and scaling, magnitudes, and the
// overflow precheck that seeds the cell row.
// ============================================================================
`default_nettype none

module tphc_front
    import tphc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [C_FRONT-1:0] i_en,
    input  wire logic               i_vld,
    input  wire t_in                i_data,
    input  wire t_cfg               i_cfg,
    output logic [C_FRONT-1:0]      o_vld,
    output t_div_pair               o_div
);

    logic [C_FRONT-1:0] r_vld;

    // Stage A: products.
    logic signed [26:0] r_a_t_p1, r_a_t_p2, r_a_t_p3;
    logic signed [16:0] r_a_t_den;
    logic signed [24:0] r_a_h_p1, r_a_h_p2, r_a_h_p3;
    logic signed [16:0] r_a_h_den;

    // Stage B: scaled numerator.
    logic signed [31:0] r_b_t_num, r_b_h_num;
    logic signed [16:0] r_b_t_den, r_b_h_den;

    // Stage C: magnitudes.
    logic [31:0] r_c_t_mag, r_c_h_mag;
    logic [15:0] r_c_t_dmag, r_c_h_dmag;
    logic        r_c_t_neg, r_c_h_neg;
    logic        r_c_t_zero, r_c_h_zero;

    // Stage D: seed of the cell row.
    t_div_pair   r_d_div;

    logic signed [10:0] w_t_dp;
    logic signed [8:0]  w_h_dp;
    logic signed [27:0] w_t_sum;
    logic signed [25:0] w_h_sum;

    function automatic logic [31:0] f_abs32(input logic signed [31:0] v);
        logic [31:0] neg_v;
        begin
            neg_v = 32'(-v);
            return v[31] ? neg_v : v;
        end
    endfunction

    function automatic logic [15:0] f_abs17(input logic signed [16:0] v);
        logic [16:0] neg_v;
        begin
            neg_v = 17'(-v);
            return v[16] ? neg_v[15:0] : v[15:0];
        end
    endfunction

    // The quotient fits in 17 bits exactly when the top 15 numerator bits
    // are below the divisor; a zero divisor always lands on the overflow side.
    function automatic t_div f_seed(input logic [31:0] mag, input logic [15:0] dmag,
                                    input logic neg, input logic zero);
        t_div d;
        begin
            d.ovf  = ({1'b0, mag[31:17]} >= dmag);
            d.rem  = {1'b0, mag[31:17]};
            d.den  = dmag;
            d.lo   = mag[16:0];
            d.quo  = '0;
            d.neg  = neg;
            d.zero = zero;
            return d;
        end
    endfunction

    assign w_t_dp = $signed({1'b0, i_cfg.temp_high_point_x8})
                  - $signed({1'b0, i_cfg.temp_low_point_x8});
    assign w_h_dp = $signed({1'b0, i_cfg.hum_high_point_x2})
                  - $signed({1'b0, i_cfg.hum_low_point_x2});

    assign w_t_sum = 28'(r_a_t_p1) + 28'(r_a_t_p2) - 28'(r_a_t_p3);
    assign w_h_sum = 26'(r_a_h_p1) + 26'(r_a_h_p2) - 26'(r_a_h_p3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_en[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int k = 1; k < C_FRONT; k++) begin
                if (i_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_t_p1  <= w_t_dp * i_data.temp_sample;
            r_a_t_p2  <= $signed({1'b0, i_cfg.temp_low_point_x8}) * i_cfg.temp_high_raw;
            r_a_t_p3  <= i_cfg.temp_low_raw * $signed({1'b0, i_cfg.temp_high_point_x8});
            r_a_t_den <= 17'(i_cfg.temp_high_raw) - 17'(i_cfg.temp_low_raw);
            r_a_h_p1  <= w_h_dp * i_data.hum_sample;
            r_a_h_p2  <= $signed({1'b0, i_cfg.hum_low_point_x2}) * i_cfg.hum_high_raw;
            r_a_h_p3  <= i_cfg.hum_low_raw * $signed({1'b0, i_cfg.hum_high_point_x2});
            r_a_h_den <= 17'(i_cfg.hum_high_raw) - 17'(i_cfg.hum_low_raw);
        end
        if (i_en[1]) begin
            r_b_t_num <= 32'(w_t_sum) <<< C_TEMP_SHIFT;
            r_b_h_num <= 32'(w_h_sum) <<< C_HUM_SHIFT;
            r_b_t_den <= r_a_t_den;
            r_b_h_den <= r_a_h_den;
        end
        if (i_en[2]) begin
            r_c_t_mag  <= f_abs32(r_b_t_num);
            r_c_h_mag  <= f_abs32(r_b_h_num);
            r_c_t_dmag <= f_abs17(r_b_t_den);
            r_c_h_dmag <= f_abs17(r_b_h_den);
            r_c_t_neg  <= r_b_t_num[31] ^ r_b_t_den[16];
            r_c_h_neg  <= r_b_h_num[31] ^ r_b_h_den[16];
            r_c_t_zero <= (r_b_t_num == '0);
            r_c_h_zero <= (r_b_h_num == '0);
        end
        if (i_en[3]) begin
            r_d_div.temp <= f_seed(r_c_t_mag, r_c_t_dmag, r_c_t_neg, r_c_t_zero);
            r_d_div.hum  <= f_seed(r_c_h_mag, r_c_h_dmag, r_c_h_neg, r_c_h_zero);
        end
    end

    assign o_vld = r_vld;
    assign o_div = r_d_div;

endmodule

`default_nettype wire

// File: rtl/tphc_cell.sv
// ============================================================================
// tphc_cell
// One restoring division step for both channels: shifts in one numerator
// bit and produces one quotient bit.
// ============================================================================
`default_nettype none

module tphc_cell
    import tphc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire logic      i_vld,
    input  wire t_div_pair i_div,
    output logic           o_vld,
    output t_div_pair      o_div
);

    logic      r_vld;
    t_div_pair r_div;
    t_div_pair n_div;

    // While ovf is clear the remainder stays below the divisor, so the trial value
    // stays below twice the divisor and the difference fits back into 16 bits.
    function automatic t_div f_step(input t_div d);
        t_div        r;
        logic [16:0] trial;
        logic [16:0] diff;
        logic        ge;
        begin
            r     = d;
            trial = {d.rem, d.lo[16]};
            diff  = trial - {1'b0, d.den};
            ge    = (trial >= {1'b0, d.den});
            r.rem = ge ? diff[15:0] : trial[15:0];
            r.lo  = {d.lo[15:0], 1'b0};
            r.quo = {d.quo[15:0], ge};
            return r;
        end
    endfunction

    always_comb begin
        n_div.temp = f_step(i_div.temp);
        n_div.hum  = f_step(i_div.hum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_vld = r_vld;
    assign o_div = r_div;

endmodule

`default_nettype wire

// File: rtl/tphc_sat.sv
// ============================================================================
// tphc_sat
// Output register: applies the sign, saturates to 16 bits and raises the
// invalid flags.
// ============================================================================
`default_nettype none

module tphc_sat
    import tphc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire logic      i_vld,
    input  wire t_div_pair i_div,
    output logic           o_vld,
    output t_out           o_data
);

    logic        r_vld;
    t_out        r_data;
    t_out        n_data;
    logic [16:0] w_t_res, w_h_res;

    // Returns {invalid, value}.
    function automatic logic [16:0] f_sat(input t_div d);
        logic [16:0] neg_q;
        logic [15:0] val;
        logic        inv;
        begin
            neg_q = 17'(~d.quo + 17'd1);
            if (d.ovf) begin
                inv = 1'b1;
                if (d.zero) begin
                    val = C_OUT_ZERO;
                end else begin
                    val = d.neg ? C_OUT_MIN : C_OUT_MAX;
                end
            end else if (d.neg) begin
                inv = (d.quo > C_NEG_LIM);
                val = inv ? C_OUT_MIN : neg_q[15:0];
            end else begin
                inv = (d.quo > C_POS_LIM);
                val = inv ? C_OUT_MAX : d.quo[15:0];
            end
            return {inv, val};
        end
    endfunction

    always_comb begin
        w_t_res             = f_sat(i_div.temp);
        w_h_res             = f_sat(i_div.hum);
        n_data.temperature  = $signed(w_t_res[15:0]);
        n_data.humidity     = $signed(w_h_res[15:0]);
        n_data.temp_invalid = w_t_res[16];
        n_data.hum_invalid  = w_h_res[16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

`default_nettype wire

// File: rtl/two_point_temp_humidity_calib_core.sv
// ============================================================================
// two_point_temp_humidity_calib_core
// Two-point linear calibration of a temperature and a humidity sample, with
// a truncating signed division carried out by a row of one-bit cells.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_ready   i_in_data  (t_in)
//   out       output     o_out_valid / i_out_ready o_out_data (t_out)
//   cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One sample pair is taken per cycle while o_in_ready is high; each result
// passes four front stages, seventeen division cells (one quotient bit each)
// and the output register, the first stage loading at the transfer edge
// itself.
// Every stage has its own enable, so a stalled output only holds back the
// stages behind it until their bubbles are filled.
// Reset clears the configuration registers and all stage valid bits.
// ============================================================================
`default_nettype none

module two_point_temp_humidity_calib_core
    import tphc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire t_in                     i_in_data,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output t_out                         o_out_data,
    input  wire logic                    i_cfg_we,
    input  wire logic [C_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [C_CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                r_cfg;
    t_cfg                n_cfg;
    logic [C_STAGES-1:0] w_en;
    logic [C_STAGES-1:0] w_vld;
    t_div_pair           w_div [0:C_CELLS];

    // Configuration registers.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                C_REG_HUM_LOW_PT:    n_cfg.hum_low_point_x2   = i_cfg_data[7:0];
                C_REG_HUM_HIGH_PT:   n_cfg.hum_high_point_x2  = i_cfg_data[7:0];
                C_REG_TEMP_LOW_PT:   n_cfg.temp_low_point_x8  = i_cfg_data[9:0];
                C_REG_TEMP_HIGH_PT:  n_cfg.temp_high_point_x8 = i_cfg_data[9:0];
                C_REG_HUM_LOW_RAW:   n_cfg.hum_low_raw        = $signed(i_cfg_data);
                C_REG_HUM_HIGH_RAW:  n_cfg.hum_high_raw       = $signed(i_cfg_data);
                C_REG_TEMP_LOW_RAW:  n_cfg.temp_low_raw       = $signed(i_cfg_data);
                C_REG_TEMP_HIGH_RAW: n_cfg.temp_high_raw      = $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    assign w_en[C_STAGES-1] = !w_vld[C_STAGES-1] || i_out_ready;

    for (genvar g = 0; g < C_STAGES - 1; g++) begin : g_en
        assign w_en[g] = !w_vld[g] || w_en[g+1];
    end

    tphc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en[C_FRONT-1:0]),
        .i_vld   (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (r_cfg),
        .o_vld   (w_vld[C_FRONT-1:0]),
        .o_div   (w_div[0])
    );

    for (genvar k = 0; k < C_CELLS; k++) begin : g_cell
        tphc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[C_FRONT+k]),
            .i_vld   (w_vld[C_FRONT+k-1]),
            .i_div   (w_div[k]),
            .o_vld   (w_vld[C_FRONT+k]),
            .o_div   (w_div[k+1])
        );
    end

    tphc_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en[C_STAGES-1]),
        .i_vld   (w_vld[C_STAGES-2]),
        .i_div   (w_div[C_CELLS]),
        .o_vld   (w_vld[C_STAGES-1]),
        .o_data  (o_out_data)
    );

    assign o_in_ready  = w_en[0];
    assign o_out_valid = w_vld[C_STAGES-1];

    // An accepted transfer always lands in the first stage.
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> w_vld[0])
        else $error("accepted input did not reach the first stage");

    // A held cell keeps its item.
    a_cell_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en[C_FRONT] |=> w_vld[C_FRONT])
        else $error("stalled division cell lost its item");

    // With the output register empty the whole row can move, so input is open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while the output register is empty");

    // Items in flight change only by transfers in and out.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(w_vld) == $past($countones(w_vld))
                + int'($past(i_in_valid && o_in_ready))
                - int'($past(o_out_valid && i_out_ready))))
        else $error("pipeline occupancy does not match the transfers");

endmodule

`default_nettype wire
